FILE: hdl/all_pairs_distance_relax_unit_macros.svh
// Assertion macros shared by the distance relaxation unit.
`ifndef ALL_PAIRS_DISTANCE_RELAX_UNIT_MACROS_SVH
`define ALL_PAIRS_DISTANCE_RELAX_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its condition.
`define APDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its condition.
`define APDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/apdr_pkg.sv
// Shared types and codes of the distance relaxation unit.
package apdr_pkg;

  // Operation codes of an input transaction
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_RELAX = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Upper bound on full sweeps made by one relax transaction
  localparam logic [6:0] PASS_LIMIT = 7'd64;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] row;
    logic [3:0] col;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic [6:0] pass_count;
  } out_item_t;

endpackage

FILE: hdl/all_pairs_distance_relax_unit.sv
// Distance matrix with write, read and relax-to-fixpoint transactions.
//
//   channel  signals                     direction  transaction
//   in       in_valid in_stall in_data   input      in_valid && !in_stall
//   out      out_valid out_stall out_data output    out_valid && !out_stall
//   cfg      cfg_wr_en cfg_wr_data       input      cfg_wr_en (node_count)
//
// A write goes through S_FIN before it loads the output register, a read through S_RDW
// and S_FIN. A relax pass reads (x, y) for each ordered pair of distinct nodes, skips
// diagonal pairs, and for each z apart from x and y reads (y, z) and (x, z); when the
// sum is smaller it writes (x, z) and then its mirror (z, x). There are at most 64
// passes; the single read port of the matrix memory makes these steps run one by one.
// Reset clears the sequencer, the output valid and node_count (16); the matrix
// holds no reset value. in_stall is high from acceptance until the result is
// loaded; a stalled result holds the block before it returns to idle.
module all_pairs_distance_relax_unit
  import apdr_pkg::*;
#(
  parameter int MAX_NODES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic [4:0] cfg_wr_data
);

  `include "all_pairs_distance_relax_unit_macros.svh"

  localparam int DEPTH = MAX_NODES * MAX_NODES;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(MAX_NODES);
  localparam int NW    = $clog2(MAX_NODES + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDW  = 9'b000000010,
    S_XY   = 9'b000000100,
    S_XYL  = 9'b000001000,
    S_Z    = 9'b000010000,
    S_YZ   = 9'b000100000,
    S_XZ   = 9'b001000000,
    S_MIR  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  // Flat address of entry (r, c)
  function automatic logic [AW-1:0] addr_of(input logic [7:0] r, input logic [7:0] c);
    return AW'(r * MAX_NODES + c);
  endfunction

  state_t          state_r, state_nxt;
  logic [IW-1:0]   x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [NW-1:0]   n_m1_r, n_m1_nxt;
  logic [6:0]      pass_r, pass_nxt;
  logic            changed_r, changed_nxt;
  logic [7:0]      dxy_r, dxy_nxt;
  logic [8:0]      sum_r, sum_nxt;
  logic [7:0]      res_read_r, res_read_nxt;
  logic [6:0]      res_pass_r, res_pass_nxt;
  in_item_t        item_r, item_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [4:0]      node_count_r;

  logic [7:0]      dist_mem [DEPTH];
  logic [7:0]      rdata_r;
  logic            rd_en, we;
  logic [AW-1:0]   raddr, waddr;
  logic [7:0]      wdata;

  logic [NW-1:0]   n_act;
  logic            in_rng, item_rng;
  logic            z_last, y_last, x_last;
  logic            adv_z, adv_y, z_wrap, y_step, y_wrap, x_wrap;
  logic [6:0]      pass_inc;

  // Active node count, clipped to the matrix size
  assign n_act = ({3'b000, node_count_r} > 8'(MAX_NODES)) ? NW'(MAX_NODES)
                                                          : NW'(node_count_r);

  assign in_rng   = (8'(in_data.row) < 8'(MAX_NODES)) && (8'(in_data.col) < 8'(MAX_NODES));
  assign item_rng = (8'(item_r.row) < 8'(MAX_NODES)) && (8'(item_r.col) < 8'(MAX_NODES));

  assign z_last   = (NW'(z_r) == n_m1_r);
  assign y_last   = (NW'(y_r) == n_m1_r);
  assign x_last   = (NW'(x_r) == n_m1_r);
  assign pass_inc = pass_r + 7'd1;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Sequencer: one memory access per cycle, loop counters advance at the end
  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    n_m1_nxt      = n_m1_r;
    pass_nxt      = pass_r;
    changed_nxt   = changed_r;
    dxy_nxt       = dxy_r;
    sum_nxt       = sum_r;
    res_read_nxt  = res_read_r;
    res_pass_nxt  = res_pass_r;
    item_nxt      = item_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    rd_en         = 1'b0;
    raddr         = '0;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    adv_z         = 1'b0;
    adv_y         = 1'b0;

    // drop the result once the consumer takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt     = in_data;
          res_read_nxt = '0;
          res_pass_nxt = '0;
          case (in_data.operation)
            OP_WRITE: begin
              we        = in_rng;
              waddr     = addr_of(8'(in_data.row), 8'(in_data.col));
              wdata     = in_data.value;
              state_nxt = S_FIN;
            end
            OP_RELAX: begin
              n_m1_nxt    = n_act - NW'(1);
              x_nxt       = '0;
              y_nxt       = '0;
              z_nxt       = '0;
              pass_nxt    = '0;
              changed_nxt = 1'b0;
              if (n_act < NW'(2)) begin
                res_pass_nxt = 7'd1;
                state_nxt    = S_FIN;
              end else begin
                state_nxt = S_XY;
              end
            end
            OP_READ: begin
              rd_en     = 1'b1;
              raddr     = addr_of(8'(in_data.row), 8'(in_data.col));
              state_nxt = S_RDW;
            end
            default: begin
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_RDW: begin
        res_read_nxt = item_rng ? rdata_r : '0;
        state_nxt    = S_FIN;
      end
      S_XY: begin
        if (x_r == y_r) begin
          adv_y = 1'b1;
        end else begin
          rd_en     = 1'b1;
          raddr     = addr_of(8'(x_r), 8'(y_r));
          state_nxt = S_XYL;
        end
      end
      S_XYL: begin
        dxy_nxt   = rdata_r;
        z_nxt     = '0;
        state_nxt = S_Z;
      end
      S_Z: begin
        if ((z_r == x_r) || (z_r == y_r)) begin
          adv_z = 1'b1;
        end else begin
          rd_en     = 1'b1;
          raddr     = addr_of(8'(y_r), 8'(z_r));
          state_nxt = S_YZ;
        end
      end
      S_YZ: begin
        sum_nxt   = {1'b0, dxy_r} + {1'b0, rdata_r};
        rd_en     = 1'b1;
        raddr     = addr_of(8'(x_r), 8'(z_r));
        state_nxt = S_XZ;
      end
      S_XZ: begin
        if (sum_r < {1'b0, rdata_r}) begin
          we          = 1'b1;
          waddr       = addr_of(8'(x_r), 8'(z_r));
          wdata       = sum_r[7:0];
          changed_nxt = 1'b1;
          state_nxt   = S_MIR;
        end else begin
          adv_z = 1'b1;
        end
      end
      S_MIR: begin
        we    = 1'b1;
        waddr = addr_of(8'(z_r), 8'(x_r));
        wdata = sum_r[7:0];
        adv_z = 1'b1;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_read_r;
          out_data_nxt.pass_count = res_pass_r;
          state_nxt               = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // advance the z, y, x loops and close a pass
    z_wrap = adv_z && z_last;
    y_step = adv_y || z_wrap;
    y_wrap = y_step && y_last;
    x_wrap = y_wrap && x_last;
    if (adv_z) begin
      z_nxt = z_last ? '0 : z_r + IW'(1);
      if (!z_last) begin
        state_nxt = S_Z;
      end
    end
    if (y_step) begin
      y_nxt = y_last ? '0 : y_r + IW'(1);
      if (!y_last) begin
        state_nxt = S_XY;
      end
    end
    if (y_wrap) begin
      x_nxt = x_last ? '0 : x_r + IW'(1);
      if (!x_last) begin
        state_nxt = S_XY;
      end
    end
    if (x_wrap) begin
      pass_nxt = pass_inc;
      if (changed_r && (pass_inc < PASS_LIMIT)) begin
        changed_nxt = 1'b0;
        state_nxt   = S_XY;
      end else begin
        res_pass_nxt = pass_inc;
        state_nxt    = S_FIN;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      node_count_r <= 5'd16;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        node_count_r <= cfg_wr_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    n_m1_r     <= n_m1_nxt;
    pass_r     <= pass_nxt;
    changed_r  <= changed_nxt;
    dxy_r      <= dxy_nxt;
    sum_r      <= sum_nxt;
    res_read_r <= res_read_nxt;
    res_pass_r <= res_pass_nxt;
    item_r     <= item_nxt;
    out_data_r <= out_data_nxt;
  end

  // Matrix memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      dist_mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= dist_mem[raddr];
    end
  end

  // Checks
  `APDR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "idle after accept")
  `APDR_ASSERT_NOW(a_mirror_follows_store, state_r == S_MIR, $past(state_r) == S_XZ,
                   "mirror store without a preceding shrink")
  `APDR_ASSERT_NOW(a_result_fields_exclusive, out_valid_r && (out_data_r.pass_count != 7'd0),
                   out_data_r.read_value == 8'd0, "relax result carries read data")
  `APDR_ASSERT_NOW(a_relax_counts_pass, (state_r == S_FIN) && (item_r.operation == OP_RELAX),
                   (res_pass_r != 7'd0) && (res_pass_r <= PASS_LIMIT), "bad pass count")

endmodule

FILE: tb/all_pairs_distance_relax_unit_tb.sv
// Self-checking testbench for the distance relaxation unit with its own matrix predictor.
module all_pairs_distance_relax_unit_tb
  import apdr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_NODES = 16;
  // Nodes whose block of entries is fully loaded before random traffic
  localparam int BLOCK = 6;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Worst handshake cost of one transaction: longest gap, longest stall, latency
  localparam longint ITEM_COST = 120;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_wr_en = 1'b0;
  logic [4:0] cfg_wr_data = '0;

  // Predicted matrix and node count
  logic [7:0] dist_model [0:MAX_NODES*MAX_NODES-1];
  logic [4:0] model_nodes = 5'd16;

  in_item_t  tx_backlog[$];
  out_item_t awaited_results[$];
  int        outstanding = 0;
  int        error_count = 0;
  int        gen_nodes = 16;
  bit        in_quiet = 1'b0;
  bit        out_quiet = 1'b0;
  int        in_gap = 0;
  int        stall_left = 0;
  longint    cycle_count = 0;
  longint    cycle_budget = 0;
  out_item_t want;

  all_pairs_distance_relax_unit #(
    .MAX_NODES(MAX_NODES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sweep all distinct triples until a pass changes nothing or the pass cap is hit
  function automatic logic [6:0] relax_model();
    int unsigned n;
    int unsigned passes;
    bit          changed;
    logic [8:0]  sum;
    n = (model_nodes > MAX_NODES) ? MAX_NODES : model_nodes;
    passes = 0;
    changed = 1'b1;
    while (changed && passes < PASS_LIMIT) begin
      changed = 1'b0;
      for (int x = 0; x < n; x++) begin
        for (int y = 0; y < n; y++) begin
          if (x != y) begin
            for (int z = 0; z < n; z++) begin
              if (z != x && z != y) begin
                sum = {1'b0, dist_model[x*MAX_NODES+y]} + {1'b0, dist_model[y*MAX_NODES+z]};
                if (sum < {1'b0, dist_model[x*MAX_NODES+z]}) begin
                  dist_model[x*MAX_NODES+z] = sum[7:0];
                  dist_model[z*MAX_NODES+x] = sum[7:0];
                  changed = 1'b1;
                end
              end
            end
          end
        end
      end
      passes++;
    end
    return passes[6:0];
  endfunction

  // Advance the predicted state by one transaction and return its result
  function automatic out_item_t apply_transaction(input in_item_t t);
    out_item_t r;
    r = '0;
    case (t.operation)
      OP_WRITE: dist_model[int'(t.row)*MAX_NODES + int'(t.col)] = t.value;
      OP_RELAX: r.pass_count = relax_model();
      OP_READ:  r.read_value = dist_model[int'(t.row)*MAX_NODES + int'(t.col)];
      default: ;
    endcase
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int pick_idle(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_distance();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
    if (r < 55) return 8'($urandom_range(1, 40));
    return 8'($urandom_range(0, 255));
  endfunction

  // Node index: mostly inside the active span, else anywhere in the loaded block
  function automatic logic [3:0] pick_node(input int span);
    if ($urandom_range(0, 99) < 85) return 4'($urandom_range(0, span - 1));
    return 4'($urandom_range(0, BLOCK - 1));
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [3:0] r, input logic [3:0] c,
                            input logic [7:0] v);
    in_item_t t;
    longint   n;
    t.operation = op;
    t.row = r;
    t.col = c;
    t.value = v;
    tx_backlog.insert(tx_backlog.size(), t);
    outstanding++;
    cycle_budget += ITEM_COST;
    if (op == OP_RELAX) begin
      n = (gen_nodes > MAX_NODES) ? MAX_NODES : gen_nodes;
      cycle_budget += 64 * (2*n*n + 4*n*n*n + 8);
    end
  endtask

  // Wait for every queued transaction to return its result
  task automatic drain();
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write node_count only once the block has gone idle
  task automatic reconfigure(input logic [4:0] v);
    drain();
    repeat (8) @(posedge clk);
    gen_nodes = int'(v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    model_nodes = v;
    cfg_wr_en <= 1'b0;
  endtask

  // Input driver: predict on each accepted transaction, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.insert(awaited_results.size(), apply_transaction(in_data));
        in_gap = pick_idle(in_quiet);
      end
      if (in_valid && in_stall) begin
        // hold the payload
      end else if (in_gap != 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (tx_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= tx_backlog[0];
        tx_backlog.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: compare against the oldest prediction, then pick the next stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          error_count++;
          $display("%0t: result with none expected: read_value %0d pass_count %0d",
                   $time, out_data.read_value, out_data.pass_count);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          outstanding--;
          if (out_data.read_value !== want.read_value) begin
            error_count++;
            $display("%0t: read_value expected %0d, got %0d",
                     $time, want.read_value, out_data.read_value);
          end
          if (out_data.pass_count !== want.pass_count) begin
            error_count++;
            $display("%0t: pass_count expected %0d, got %0d",
                     $time, want.pass_count, out_data.pass_count);
          end
        end
      end
      if (stall_left == 0) stall_left = pick_idle(out_quiet);
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: several times the slowest legal run of what has been queued
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 4 * cycle_budget + 40000) begin
      $display("all_pairs_distance_relax_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int          random_items;
    int          pick;
    int          span;
    int          len;
    logic [4:0]  cfg;
    logic [3:0]  r;
    logic [3:0]  c;
    logic [7:0]  v;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, diagonal entry, unused operation code
    queue_item(OP_WRITE, 4'd0, 4'd15, 8'd255);
    queue_item(OP_WRITE, 4'd15, 4'd0, 8'd0);
    queue_item(OP_WRITE, 4'd7, 4'd7, 8'd128);
    queue_item(OP_READ, 4'd0, 4'd15, 8'd0);
    queue_item(OP_READ, 4'd15, 4'd0, 8'd255);
    queue_item(OP_READ, 4'd7, 4'd7, 8'd0);
    queue_item(OP_UNUSED, 4'd15, 4'd15, 8'd255);
    queue_item(OP_UNUSED, 4'd0, 4'd0, 8'd0);
    queue_item(OP_WRITE, 4'd0, 4'd1, 8'd10);
    queue_item(OP_WRITE, 4'd1, 4'd0, 8'd7);

    // Two nodes: no distinct triple, so one quiet pass
    reconfigure(5'd2);
    queue_item(OP_RELAX, 4'd0, 4'd0, 8'd0);
    queue_item(OP_READ, 4'd0, 4'd1, 8'd0);

    // Three nodes: a sum past 255 must not wrap, and an asymmetric shortcut
    reconfigure(5'd3);
    queue_item(OP_WRITE, 4'd0, 4'd2, 8'd250);
    queue_item(OP_WRITE, 4'd2, 4'd0, 8'd255);
    queue_item(OP_WRITE, 4'd1, 4'd2, 8'd100);
    queue_item(OP_WRITE, 4'd2, 4'd1, 8'd2);
    queue_item(OP_WRITE, 4'd0, 4'd1, 8'd200);
    queue_item(OP_WRITE, 4'd1, 4'd0, 8'd1);
    queue_item(OP_RELAX, 4'd0, 4'd0, 8'd0);
    queue_item(OP_READ, 4'd0, 4'd2, 8'd0);
    queue_item(OP_READ, 4'd2, 4'd0, 8'd0);
    queue_item(OP_READ, 4'd1, 4'd2, 8'd0);

    // Node counts below two
    reconfigure(5'd0);
    queue_item(OP_RELAX, 4'd0, 4'd0, 8'd0);
    reconfigure(5'd1);
    queue_item(OP_RELAX, 4'd15, 4'd15, 8'd255);

    // Load the whole block, then relax over it
    reconfigure(5'(BLOCK));
    for (int i = 0; i < BLOCK; i++)
      for (int j = 0; j < BLOCK; j++)
        queue_item(OP_WRITE, 4'(i), 4'(j), pick_distance());
    queue_item(OP_RELAX, 4'd0, 4'd0, 8'd0);
    repeat (2) queue_item(OP_READ, pick_node(BLOCK), pick_node(BLOCK), 8'd0);

    // Random rounds inside the block: new node count, edits, relaxes, reads and unused codes
    random_items = 0;
    while (random_items < 36) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        cfg = 5'($urandom_range(0, 1));
      end else begin
        cfg = 5'($urandom_range(2, BLOCK));
      end
      in_quiet = ($urandom_range(0, 4) == 0);
      out_quiet = ($urandom_range(0, 4) == 0);
      reconfigure(cfg);
      span = (cfg < 2) ? 2 : int'(cfg);
      len = $urandom_range(5, 12);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        r = pick_node(span);
        c = pick_node(span);
        v = pick_distance();
        if (pick < 50) begin
          queue_item(OP_WRITE, r, c, v);
          random_items++;
          if ($urandom_range(0, 2) != 0) begin
            queue_item(OP_WRITE, c, r, v);
            random_items++;
          end
        end else if (pick < 62) begin
          queue_item(OP_RELAX, r, c, v);
          random_items++;
        end else if (pick < 92) begin
          queue_item(OP_READ, r, c, v);
          random_items++;
        end else begin
          queue_item(OP_UNUSED, r, c, v);
          random_items++;
        end
      end
      queue_item(OP_RELAX, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                 8'($urandom_range(0, 255)));
      queue_item(OP_READ, pick_node(span), pick_node(span), 8'd0);
      queue_item(OP_READ, pick_node(span), pick_node(span), 8'd0);
      random_items += 3;
    end

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("all_pairs_distance_relax_unit_tb: done, clean");
    end else begin
      $display("all_pairs_distance_relax_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hdl
hdl/apdr_pkg.sv
hdl/all_pairs_distance_relax_unit.sv
tb/all_pairs_distance_relax_unit_tb.sv
